// ----- rtl/core/zgs_pkg.sv -----
// ---------------------------------------------------------------------------
// zgs_pkg: shared types and codes for the zoom grid snap and step block
// Request mode codes, direction codes, register indexes and the control
// group that travels down the pipeline with each beat.
// ---------------------------------------------------------------------------
`default_nettype none

package zgs_pkg;

  // request modes
  localparam logic [1:0] MODE_CHECK = 2'd0;
  localparam logic [1:0] MODE_SNAP  = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;

  // direction codes, two's complement
  localparam logic [1:0] DIR_ZERO = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_NEG2 = 2'b10;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP = 2'd0;
  localparam logic [1:0] CFG_MIN  = 2'd1;
  localparam logic [1:0] CFG_MAX  = 2'd2;

  // reset values, truncated to the zoom width at use
  localparam logic [15:0] RST_STEP = 16'd10;
  localparam logic [15:0] RST_MIN  = 16'd10;
  localparam logic [15:0] RST_MAX  = 16'd300;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] dir;
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/zgs_prep.sv -----
// ---------------------------------------------------------------------------
// zgs_prep: request entry stage
// Registers the request and forms the offset from the grid origin that the
// divider reduces modulo the step.
// ---------------------------------------------------------------------------
`default_nettype none

module zgs_prep #(
  parameter int W = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          v_i,
  input  wire logic [1:0]    mode_i,
  input  wire logic [W-1:0]  cur_i,
  input  wire logic [1:0]    dir_i,
  input  wire logic [W-1:0]  lo_i,
  output zgs_pkg::ctl_t      ctl_o,
  output logic               v_o,
  output logic [W-1:0]       cur_o,
  output logic [W-1:0]       dvd_o
);
  import zgs_pkg::*;

  logic         v_q;
  ctl_t         ctl_q;
  logic [W-1:0] cur_q;
  logic [W-1:0] dvd_q;
  logic [W-1:0] dvd_d;

  // a step down looks for the grid point strictly below, hence the extra one
  always_comb begin
    if (mode_i == MODE_STEP && dir_i == DIR_DOWN) begin
      dvd_d = cur_i - lo_i - W'(1);
    end else begin
      dvd_d = cur_i - lo_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q.mode <= mode_i;
      ctl_q.dir  <= dir_i;
      cur_q      <= cur_i;
      dvd_q      <= dvd_d;
    end
  end

  assign v_o   = v_q;
  assign ctl_o = ctl_q;
  assign cur_o = cur_q;
  assign dvd_o = dvd_q;

endmodule

`default_nettype wire

// ----- rtl/core/zgs_div_stage.sv -----
// ---------------------------------------------------------------------------
// zgs_div_stage: one bit of the remainder pipeline
// Shifts in one dividend bit and subtracts the step when it fits, so that
// W stages in a row leave the offset modulo the step.
// ---------------------------------------------------------------------------
`default_nettype none

module zgs_div_stage #(
  parameter int W   = 12,
  parameter int IDX = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          v_i,
  input  wire zgs_pkg::ctl_t ctl_i,
  input  wire logic [W-1:0]  cur_i,
  input  wire logic [W-1:0]  dvd_i,
  input  wire logic [W-1:0]  rem_i,
  input  wire logic [W-1:0]  st_i,
  output logic               v_o,
  output zgs_pkg::ctl_t      ctl_o,
  output logic [W-1:0]       cur_o,
  output logic [W-1:0]       dvd_o,
  output logic [W-1:0]       rem_o
);
  import zgs_pkg::*;

  logic         v_q;
  ctl_t         ctl_q;
  logic [W-1:0] cur_q;
  logic [W-1:0] dvd_q;
  logic [W-1:0] rem_q;
  logic [W:0]   sh;
  logic [W-1:0] rem_d;

  // msb first: stage IDX takes bit W-1-IDX
  always_comb begin
    sh = {rem_i, dvd_i[W-1-IDX]};
    if (sh >= {1'b0, st_i}) begin
      rem_d = W'(sh - {1'b0, st_i});
    end else begin
      rem_d = sh[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_i;
      cur_q <= cur_i;
      dvd_q <= dvd_i;
      rem_q <= rem_d;
    end
  end

  assign v_o   = v_q;
  assign ctl_o = ctl_q;
  assign cur_o = cur_q;
  assign dvd_o = dvd_q;
  assign rem_o = rem_q;

endmodule

`default_nettype wire

// ----- rtl/core/zgs_finish.sv -----
// ---------------------------------------------------------------------------
// zgs_finish: candidate and selection stages
// From the remainder, builds the grid point below and the one above, then
// picks the result for the mode and drives the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module zgs_finish #(
  parameter int W = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          v_i,
  input  wire zgs_pkg::ctl_t ctl_i,
  input  wire logic [W-1:0]  cur_i,
  input  wire logic [W-1:0]  rem_i,
  input  wire logic [W-1:0]  st_i,
  input  wire logic [W-1:0]  lo_i,
  input  wire logic [W-1:0]  hi_i,
  output logic               v_o,
  output logic               ok_o,
  output logic [W-1:0]       tgt_o
);
  import zgs_pkg::*;

  // candidate stage
  logic         a_v_q;
  ctl_t         a_ctl_q;
  logic [W-1:0] a_cur_q;
  logic [W-1:0] a_base_q;
  logic [W:0]   a_nxt_q;
  logic         a_legal_q;
  logic         a_cfg_ok_q;
  logic         a_rng_q;
  logic [W-1:0] base_d;
  logic         cfg_ok;
  logic         in_rng;

  // output stage
  logic         o_v_q;
  logic         o_ok_q;
  logic [W-1:0] o_tgt_q;
  logic         ok_d;
  logic [W-1:0] tgt_d;
  logic [W:0]   sel;
  logic [W:0]   best_d;
  logic [W:0]   d_up;
  logic [W:0]   d_hi;
  logic [W:0]   hi_x;
  logic         dir_nonneg;

  assign cfg_ok = (st_i != '0) && (lo_i <= hi_i);
  assign in_rng = (cur_i >= lo_i) && (cur_i <= hi_i);

  always_comb begin
    if (ctl_i.mode == MODE_STEP && ctl_i.dir == DIR_DOWN) begin
      base_d = cur_i - W'(1) - rem_i;
    end else begin
      base_d = cur_i - rem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= v_i;
      o_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ctl_q    <= ctl_i;
      a_cur_q    <= cur_i;
      a_base_q   <= base_d;
      a_nxt_q    <= {1'b0, base_d} + {1'b0, st_i};
      a_legal_q  <= cfg_ok && in_rng && ((cur_i == hi_i) || (rem_i == '0));
      a_cfg_ok_q <= cfg_ok;
      a_rng_q    <= in_rng;
      o_ok_q     <= ok_d;
      o_tgt_q    <= tgt_d;
    end
  end

  assign hi_x       = {1'b0, hi_i};
  assign dir_nonneg = !a_ctl_q.dir[1];

  always_comb begin
    ok_d   = 1'b0;
    tgt_d  = '0;
    sel    = {1'b0, a_base_q};
    best_d = {1'b0, a_cur_q - a_base_q};
    d_up   = a_nxt_q - {1'b0, a_cur_q};
    d_hi   = hi_x - {1'b0, a_cur_q};
    case (a_ctl_q.mode)
      MODE_CHECK: begin
        ok_d = a_legal_q;
      end
      MODE_SNAP: begin
        // nearest of lower point, upper point if legal, and max
        if (a_nxt_q <= hi_x) begin
          if (d_up < best_d || (d_up == best_d && dir_nonneg)) begin
            sel    = a_nxt_q;
            best_d = d_up;
          end
        end
        if (d_hi < best_d || (d_hi == best_d && dir_nonneg && hi_x > sel)) begin
          sel = hi_x;
        end
        ok_d  = a_cfg_ok_q && a_rng_q && (a_ctl_q.dir != DIR_NEG2);
        tgt_d = sel[W-1:0];
      end
      MODE_STEP: begin
        if (a_ctl_q.dir == DIR_UP) begin
          ok_d = a_cfg_ok_q && (a_cur_q < hi_i);
          if (a_cur_q < lo_i) begin
            tgt_d = lo_i;
          end else if (a_nxt_q < hi_x) begin
            tgt_d = a_nxt_q[W-1:0];
          end else begin
            tgt_d = hi_i;
          end
        end else if (a_ctl_q.dir == DIR_DOWN) begin
          ok_d = a_cfg_ok_q && (a_cur_q > lo_i);
          if (a_cur_q > hi_i) begin
            tgt_d = hi_i;
          end else begin
            tgt_d = a_base_q;
          end
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (!ok_d) begin
      tgt_d = '0;
    end
  end

  assign v_o   = o_v_q;
  assign ok_o  = o_ok_q;
  assign tgt_o = o_tgt_q;

endmodule

`default_nettype wire

// ----- rtl/core/zoom_grid_snap_and_step.sv -----
// ---------------------------------------------------------------------------
// zoom_grid_snap_and_step: zoom grid check, snap and step in tenths
// The pipeline has one entry stage, one remainder stage per bit of the zoom
// width, then candidate and output stages. Throughput is one beat per cycle;
// the whole pipeline holds while the output beat is stalled. Reset empties
// the pipeline and loads step 10, min 10 and max 300 tenths.
// ---------------------------------------------------------------------------
`default_nettype none

module zoom_grid_snap_and_step #(
  parameter int ZOOM_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [ZOOM_BITS-1:0]  cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            mode_i,
  input  wire logic [ZOOM_BITS-1:0]  current_tenths_i,
  input  wire logic signed [1:0]     direction_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       ok_o,
  output logic [ZOOM_BITS-1:0]       target_tenths_o
);
  import zgs_pkg::*;

  localparam int W = ZOOM_BITS;

  logic [W-1:0] step_q;
  logic [W-1:0] min_q;
  logic [W-1:0] max_q;
  logic         en;

  logic         v_s   [0:W];
  ctl_t         ctl_s [0:W];
  logic [W-1:0] cur_s [0:W];
  logic [W-1:0] dvd_s [0:W];
  logic [W-1:0] rem_s [0:W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= W'(RST_STEP);
      min_q  <= W'(RST_MIN);
      max_q  <= W'(RST_MAX);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP: step_q <= cfg_data_i;
        CFG_MIN:  min_q  <= cfg_data_i;
        CFG_MAX:  max_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // everything moves unless a finished beat is held at the output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  zgs_prep #(.W(W)) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (in_valid_i),
    .mode_i (mode_i),
    .cur_i  (current_tenths_i),
    .dir_i  (direction_i),
    .lo_i   (min_q),
    .ctl_o  (ctl_s[0]),
    .v_o    (v_s[0]),
    .cur_o  (cur_s[0]),
    .dvd_o  (dvd_s[0])
  );

  assign rem_s[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_div
    zgs_div_stage #(.W(W), .IDX(i)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .v_i    (v_s[i]),
      .ctl_i  (ctl_s[i]),
      .cur_i  (cur_s[i]),
      .dvd_i  (dvd_s[i]),
      .rem_i  (rem_s[i]),
      .st_i   (step_q),
      .v_o    (v_s[i+1]),
      .ctl_o  (ctl_s[i+1]),
      .cur_o  (cur_s[i+1]),
      .dvd_o  (dvd_s[i+1]),
      .rem_o  (rem_s[i+1])
    );
  end

  zgs_finish #(.W(W)) u_finish (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (v_s[W]),
    .ctl_i  (ctl_s[W]),
    .cur_i  (cur_s[W]),
    .rem_i  (rem_s[W]),
    .st_i   (step_q),
    .lo_i   (min_q),
    .hi_i   (max_q),
    .v_o    (out_valid_o),
    .ok_o   (ok_o),
    .tgt_o  (target_tenths_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/zoom_grid_snap_and_step_tb.sv -----
// ---------------------------------------------------------------------------
// zoom_grid_snap_and_step_tb: self-checking bench for the zoom grid block
// A short table of hand-picked requests on the reset grid, then random
// requests over a series of grid settings (degenerate ones among them).
// Each output beat is checked against a typed row's result or a grid rules model.
// ---------------------------------------------------------------------------
module zoom_grid_snap_and_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zgs_pkg::*;

  localparam int ZW = 12;
  localparam int ZMAX = (1 << ZW) - 1;
  localparam int NUM_SETS = 9;
  localparam int REQS_PER_SET = 135;
  localparam int HOLD_CYCLES = 100;
  localparam int DRAIN_CYCLES = ZW + 3 + 20;
  localparam int CYCLE_LIMIT = 300000;
  localparam int NUM_ROWS = 26;

  // no meaning in the block, must be refused
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic          ok;
    logic [ZW-1:0] target;
  } zoom_result_t;

  typedef struct packed {
    logic [1:0]    mode;
    logic [ZW-1:0] zoom;
    logic [1:0]    dir;
    logic          typed;
    logic          ok;
    logic [ZW-1:0] target;
  } zoom_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_idx_i = CFG_STEP;
  logic [ZW-1:0] cfg_data_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [1:0]    mode_i = MODE_CHECK;
  logic [ZW-1:0] current_tenths_i = '0;
  logic [1:0]    direction_i = DIR_ZERO;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic          ok_o;
  logic [ZW-1:0] target_tenths_o;

  // grid as the block should see it
  logic [ZW-1:0] grid_step = ZW'(10);
  logic [ZW-1:0] grid_min = ZW'(10);
  logic [ZW-1:0] grid_max = ZW'(300);

  zoom_result_t  zoom_expect_q[$];
  zoom_result_t  oldest_zoom;
  int            cycle_count = 0;
  int            mismatch_count = 0;
  int            results_checked = 0;
  int            mode_count[4] = '{0, 0, 0, 0};
  int            tx_idle_pct = 6;
  int            rx_idle_pct = 65;
  int            hold_offs = 0;
  bit            hold_off_req = 1'b0;

  zoom_row_t directed_rows [NUM_ROWS] = '{
    '{MODE_CHECK, 12'd10,   DIR_ZERO, 1'b1, 1'b1, 12'd0},
    '{MODE_CHECK, 12'd300,  DIR_ZERO, 1'b1, 1'b1, 12'd0},
    '{MODE_CHECK, 12'd15,   DIR_UP,   1'b1, 1'b0, 12'd0},
    '{MODE_CHECK, 12'd0,    DIR_DOWN, 1'b1, 1'b0, 12'd0},
    '{MODE_CHECK, 12'd4095, DIR_NEG2, 1'b1, 1'b0, 12'd0},
    '{MODE_SNAP,  12'd14,   DIR_ZERO, 1'b1, 1'b1, 12'd10},
    '{MODE_SNAP,  12'd15,   DIR_DOWN, 1'b1, 1'b1, 12'd10},
    '{MODE_SNAP,  12'd15,   DIR_UP,   1'b1, 1'b1, 12'd20},
    '{MODE_SNAP,  12'd15,   DIR_ZERO, 1'b1, 1'b1, 12'd20},
    '{MODE_SNAP,  12'd15,   DIR_NEG2, 1'b1, 1'b0, 12'd0},
    '{MODE_SNAP,  12'd5,    DIR_UP,   1'b1, 1'b0, 12'd0},
    '{MODE_SNAP,  12'd301,  DIR_DOWN, 1'b1, 1'b0, 12'd0},
    '{MODE_SNAP,  12'd300,  DIR_UP,   1'b1, 1'b1, 12'd300},
    '{MODE_SNAP,  12'd296,  DIR_DOWN, 1'b0, 1'b0, 12'd0},
    '{MODE_STEP,  12'd10,   DIR_UP,   1'b1, 1'b1, 12'd20},
    '{MODE_STEP,  12'd15,   DIR_UP,   1'b1, 1'b1, 12'd20},
    '{MODE_STEP,  12'd300,  DIR_UP,   1'b1, 1'b0, 12'd0},
    '{MODE_STEP,  12'd0,    DIR_UP,   1'b1, 1'b1, 12'd10},
    '{MODE_STEP,  12'd299,  DIR_UP,   1'b0, 1'b0, 12'd0},
    '{MODE_STEP,  12'd10,   DIR_DOWN, 1'b1, 1'b0, 12'd0},
    '{MODE_STEP,  12'd15,   DIR_DOWN, 1'b1, 1'b1, 12'd10},
    '{MODE_STEP,  12'd20,   DIR_DOWN, 1'b1, 1'b1, 12'd10},
    '{MODE_STEP,  12'd4095, DIR_DOWN, 1'b1, 1'b1, 12'd300},
    '{MODE_STEP,  12'd20,   DIR_ZERO, 1'b1, 1'b0, 12'd0},
    '{MODE_STEP,  12'd20,   DIR_NEG2, 1'b1, 1'b0, 12'd0},
    '{MODE_NONE,  12'd4095, DIR_NEG2, 1'b1, 1'b0, 12'd0}
  };

  zoom_grid_snap_and_step #(
    .ZOOM_BITS(ZW)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .current_tenths_i(current_tenths_i),
    .direction_i     (direction_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ok_o            (ok_o),
    .target_tenths_o (target_tenths_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic zoom_result_t predict_zoom(logic [1:0] mode, logic [ZW-1:0] zoom,
                                                logic [1:0] dir);
    int st, lo, hi, z, lower, upper, pick, best_gap, gap;
    zoom_result_t res;
    st = grid_step;
    lo = grid_min;
    hi = grid_max;
    z = zoom;
    res = '0;
    if (st != 0 && lo <= hi) begin
      case (mode)
        MODE_CHECK: begin
          res.ok = (z >= lo) && (z <= hi) && ((z == hi) || ((z - lo) % st == 0));
        end
        MODE_SNAP: begin
          if (dir != DIR_NEG2 && z >= lo && z <= hi) begin
            lower = lo + ((z - lo) / st) * st;
            upper = lower + st;
            pick = lower;
            best_gap = z - lower;
            // ties go up unless the direction is down
            if (upper <= hi) begin
              gap = upper - z;
              if (gap < best_gap || (gap == best_gap && dir != DIR_DOWN)) begin
                pick = upper;
                best_gap = gap;
              end
            end
            gap = hi - z;
            if (gap < best_gap || (gap == best_gap && dir != DIR_DOWN && hi > pick)) begin
              pick = hi;
            end
            res.ok = 1'b1;
            res.target = ZW'(pick);
          end
        end
        MODE_STEP: begin
          if (dir == DIR_UP && z < hi) begin
            if (z < lo) begin
              pick = lo;
            end else begin
              pick = lo + ((z - lo) / st + 1) * st;
              if (pick > hi) pick = hi;
            end
            res.ok = 1'b1;
            res.target = ZW'(pick);
          end else if (dir == DIR_DOWN && z > lo) begin
            if (z > hi) pick = hi;
            else pick = lo + ((z - lo - 1) / st) * st;
            res.ok = 1'b1;
            res.target = ZW'(pick);
          end
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // random zoom, mostly near the range ends and grid points
  function automatic logic [ZW-1:0] pick_zoom();
    int v, k, st;
    st = (grid_step == 0) ? 1 : int'(grid_step);
    k = $urandom_range(ZMAX / st);
    case ($urandom_range(4))
      0: v = $urandom_range(ZMAX);
      1: v = int'(grid_min) + int'($urandom_range(6)) - 3;
      2: v = int'(grid_max) + int'($urandom_range(6)) - 3;
      3: v = int'(grid_min) + k * st + int'($urandom_range(2)) - 1;
      default: v = int'(grid_min) + k * st + st / 2;
    endcase
    if (v < 0) v = 0;
    if (v > ZMAX) v = ZMAX;
    return ZW'(v);
  endfunction

  function automatic logic [1:0] pick_dir();
    int r;
    r = $urandom_range(9);
    if (r < 4) return DIR_UP;
    if (r < 8) return DIR_DOWN;
    if (r == 8) return DIR_ZERO;
    return DIR_NEG2;
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(19);
    if (r < 6) return MODE_CHECK;
    if (r < 13) return MODE_SNAP;
    if (r < 19) return MODE_STEP;
    return MODE_NONE;
  endfunction

  // offers one request and books its expected result once the beat is taken
  task automatic offer_request(logic [1:0] mode, logic [ZW-1:0] zoom, logic [1:0] dir,
                               logic typed, zoom_result_t fixed);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    current_tenths_i <= zoom;
    direction_i <= dir;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    zoom_expect_q.push_back(typed ? fixed : predict_zoom(mode, zoom, dir));
    mode_count[mode]++;
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (zoom_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // block is empty here, so the grid can change
  task automatic load_grid(logic [ZW-1:0] st, logic [ZW-1:0] lo, logic [ZW-1:0] hi);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_STEP;
    cfg_data_i <= st;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MIN;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MAX;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_step = st;
    grid_min = lo;
    grid_max = hi;
  endtask

  // output side: random stalls, plus a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_offs++;
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (zoom_expect_q.size() == 0) begin
        $display("%0t: unexpected result beat ok=%0b target=%0d", $time, ok_o,
                 target_tenths_o);
        mismatch_count++;
      end else begin
        oldest_zoom = zoom_expect_q.pop_front();
        results_checked++;
        if (ok_o !== oldest_zoom.ok) begin
          $display("%0t: ok mismatch, expected %0b, got %0b", $time, oldest_zoom.ok, ok_o);
          mismatch_count++;
        end
        if (target_tenths_o !== oldest_zoom.target) begin
          $display("%0t: target mismatch, expected %0d, got %0d", $time,
                   oldest_zoom.target, target_tenths_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: run limit reached with %0d results outstanding", $time,
             zoom_expect_q.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [ZW-1:0] rnd_step, rnd_min, rnd_max;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-picked requests on the reset grid
    for (int i = 0; i < NUM_ROWS; i++) begin
      offer_request(directed_rows[i].mode, directed_rows[i].zoom, directed_rows[i].dir,
                    directed_rows[i].typed, {directed_rows[i].ok, directed_rows[i].target});
    end

    for (int s = 0; s < NUM_SETS; s++) begin
      wait_until_drained();
      if (s == 3) begin
        tx_idle_pct = 65;
        rx_idle_pct = 6;
      end else if (s == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      rnd_step = ($urandom_range(3) == 0) ? ZW'($urandom_range(ZMAX, 1))
                                          : ZW'($urandom_range(64, 1));
      rnd_min = ZW'($urandom_range(2000));
      rnd_max = rnd_min + ZW'($urandom_range(ZMAX - 2000));
      case (s)
        0: load_grid(ZW'(1), ZW'(0), ZW'(ZMAX));
        1: load_grid(ZW'(7), ZW'(3), ZW'(100));
        2: load_grid(rnd_step, rnd_min, rnd_max);
        3: load_grid(ZW'(0), ZW'(10), ZW'(300));
        4: load_grid(ZW'(ZMAX), ZW'(0), ZW'(ZMAX));
        5: load_grid(ZW'(10), ZW'(300), ZW'(10));
        6: load_grid(rnd_step, rnd_min, rnd_max);
        7: load_grid(ZW'(ZMAX), ZW'(ZMAX), ZW'(ZMAX));
        default: load_grid(ZW'(3), ZW'(5), ZW'(ZMAX - 1));
      endcase
      for (int n = 0; n < REQS_PER_SET; n++) begin
        // long output hold-off while requests keep coming, fills the pipeline
        if (tx_idle_pct == 0 && n == 20) hold_off_req = 1'b1;
        offer_request(pick_mode(), pick_zoom(), pick_dir(), 1'b0, '0);
      end
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d check, %0d snap, %0d step and %0d undefined-mode requests",
             mode_count[MODE_CHECK], mode_count[MODE_SNAP], mode_count[MODE_STEP],
             mode_count[MODE_NONE]);
    $display("over %0d grid settings, %0d results checked, %0d long output hold-offs",
             NUM_SETS + 1, results_checked, hold_offs);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
